// ===== rtl/wip_pkg.sv =====
// ----------------------------------------------------------------------------
// wip_pkg: shared types and constants for the wavetable player
// Action codes, configuration register indexes, back-end sequencer states
// and default geometry.
// ----------------------------------------------------------------------------
package wip_pkg;

  localparam int DEF_ADDR_BITS   = 12;
  localparam int DEF_FRAC_BITS   = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // step, rate and offset registers are fixed at this width
  localparam int REG_W       = 29;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RESET = 2'd2,
    ACT_ADD   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH  = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_OFFSET  = 2'd2,
    CFG_LOOPING = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_EXEC,
    ST_MOD,
    ST_MODFIX,
    ST_OFF,
    ST_RD1,
    ST_MUL,
    ST_FIN
  } back_state_t;

endpackage

// ===== rtl/wip_front.sv =====
// ----------------------------------------------------------------------------
// wip_front: input side of the wavetable player
// Holds the configuration registers, takes input transfers, saturates the
// position step against the table span and pushes each item into the queue.
// ----------------------------------------------------------------------------
module wip_front #(
  parameter int ADDR_BITS   = wip_pkg::DEF_ADDR_BITS,
  parameter int FRAC_BITS   = wip_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = wip_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wip_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wip_pkg::REG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           in_action,
  input  logic [ADDR_BITS-1:0]                 in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0]        in_sample_value,
  input  logic signed [wip_pkg::REG_W-1:0]     in_time_step,
  input  logic                                 q_full,
  output logic                                 q_push,
  output wip_pkg::action_t                     q_action,
  output logic [ADDR_BITS-1:0]                 q_addr,
  output logic signed [SAMPLE_BITS-1:0]        q_value,
  output logic signed [ADDR_BITS+FRAC_BITS:0]  q_step,
  output logic [ADDR_BITS:0]                   len,
  output logic [ADDR_BITS+FRAC_BITS:0]         span,
  output logic signed [ADDR_BITS+FRAC_BITS:0]  off_sat,
  output logic                                 looping
);
  import wip_pkg::*;

  localparam int LEN_W  = ADDR_BITS + 1;
  localparam int SPAN_W = ADDR_BITS + FRAC_BITS + 1;
  localparam int SX_W   = ((REG_W > SPAN_W) ? REG_W : SPAN_W) + 1;

  localparam logic [LEN_W-1:0] LEN_MIN  = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(1) << ADDR_BITS;
  localparam logic [REG_W-1:0] RATE_RST = REG_W'(1) << FRAC_BITS;

  logic [LEN_W-1:0]  len_reg_r, len_reg_nxt;
  logic [REG_W-1:0]  rate_r, rate_nxt;
  logic [REG_W-1:0]  offset_r, offset_nxt;
  logic              looping_r, looping_nxt;
  logic [SPAN_W-1:0] lim;
  action_t           act;

  function automatic logic signed [SPAN_W-1:0] sat_step(input logic [REG_W-1:0]  x,
                                                        input logic [SPAN_W-1:0] lim_in);
    logic signed [SX_W-1:0] xe;
    logic signed [SX_W-1:0] le;
    xe = {{(SX_W-REG_W){x[REG_W-1]}}, x};
    le = {{(SX_W-SPAN_W){1'b0}}, lim_in};
    if (xe > le) begin
      sat_step = SPAN_W'(le);
    end else if (xe < -le) begin
      sat_step = SPAN_W'(-le);
    end else begin
      sat_step = SPAN_W'(xe);
    end
  endfunction

  // configuration writes
  always_comb begin
    len_reg_nxt = len_reg_r;
    rate_nxt    = rate_r;
    offset_nxt  = offset_r;
    looping_nxt = looping_r;
    if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LENGTH:  len_reg_nxt = cfg_data[LEN_W-1:0];
        CFG_RATE:    rate_nxt    = cfg_data;
        CFG_OFFSET:  offset_nxt  = cfg_data;
        CFG_LOOPING: looping_nxt = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_reg_r <= LEN_MAX;
      rate_r    <= RATE_RST;
      offset_r  <= '0;
      looping_r <= 1'b0;
    end else begin
      len_reg_r <= len_reg_nxt;
      rate_r    <= rate_nxt;
      offset_r  <= offset_nxt;
      looping_r <= looping_nxt;
    end
  end

  always_comb begin
    if (len_reg_r < LEN_MIN) begin
      len = LEN_MIN;
    end else if (len_reg_r > LEN_MAX) begin
      len = LEN_MAX;
    end else begin
      len = len_reg_r;
    end
  end

  assign span    = {len, {FRAC_BITS{1'b0}}};
  assign lim     = span - SPAN_W'(1);
  assign off_sat = sat_step(offset_r, lim);
  assign looping = looping_r;

  // classify and push
  assign act      = action_t'(in_action);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign q_action = act;
  assign q_addr   = in_sample_index;
  assign q_value  = in_sample_value;
  assign q_step   = sat_step((act == ACT_TICK) ? rate_r : in_time_step, lim);

endmodule

// ===== rtl/wip_queue.sv =====
// ----------------------------------------------------------------------------
// wip_queue: short item queue of the wavetable player
// Holds classified items between the input side and the sequencer so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module wip_queue #(
  parameter int ADDR_BITS   = wip_pkg::DEF_ADDR_BITS,
  parameter int FRAC_BITS   = wip_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = wip_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 push,
  input  wip_pkg::action_t                     push_action,
  input  logic [ADDR_BITS-1:0]                 push_addr,
  input  logic signed [SAMPLE_BITS-1:0]        push_value,
  input  logic signed [ADDR_BITS+FRAC_BITS:0]  push_step,
  output logic                                 full,
  input  logic                                 pop,
  output logic                                 valid,
  output wip_pkg::action_t                     head_action,
  output logic [ADDR_BITS-1:0]                 head_addr,
  output logic signed [SAMPLE_BITS-1:0]        head_value,
  output logic signed [ADDR_BITS+FRAC_BITS:0]  head_step
);
  import wip_pkg::*;

  localparam int SPAN_W = ADDR_BITS + FRAC_BITS + 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

  action_t                  act_r   [QUEUE_DEPTH];
  logic [ADDR_BITS-1:0]     addr_r  [QUEUE_DEPTH];
  logic signed [SAMPLE_BITS-1:0] value_r [QUEUE_DEPTH];
  logic signed [SPAN_W-1:0] step_r  [QUEUE_DEPTH];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      ptr_inc = '0;
    end else begin
      ptr_inc = p + PTR_W'(1);
    end
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      act_r[wr_ptr_r]   <= push_action;
      addr_r[wr_ptr_r]  <= push_addr;
      value_r[wr_ptr_r] <= push_value;
      step_r[wr_ptr_r]  <= push_step;
    end
  end

  assign full        = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign valid       = (cnt_r != '0);
  assign head_action = act_r[rd_ptr_r];
  assign head_addr   = addr_r[rd_ptr_r];
  assign head_value  = value_r[rd_ptr_r];
  assign head_step   = step_r[rd_ptr_r];

endmodule

// ===== rtl/wip_back.sv =====
// ----------------------------------------------------------------------------
// wip_back: sequencer of the wavetable player
// Carries out queued items: position update with wrap or clamp, an
// iterative remainder for far wraps, two reads from the sample table,
// interpolation and the output register.
// ----------------------------------------------------------------------------
module wip_back #(
  parameter int ADDR_BITS   = wip_pkg::DEF_ADDR_BITS,
  parameter int FRAC_BITS   = wip_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = wip_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  wip_pkg::action_t                     q_action,
  input  logic [ADDR_BITS-1:0]                 q_addr,
  input  logic signed [SAMPLE_BITS-1:0]        q_value,
  input  logic signed [ADDR_BITS+FRAC_BITS:0]  q_step,
  input  logic [ADDR_BITS:0]                   len,
  input  logic [ADDR_BITS+FRAC_BITS:0]         span,
  input  logic signed [ADDR_BITS+FRAC_BITS:0]  off_sat,
  input  logic                                 looping,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]        out_sample_out,
  output logic                                 out_finished
);
  import wip_pkg::*;

  localparam int LEN_W     = ADDR_BITS + 1;
  localparam int SPAN_W    = ADDR_BITS + FRAC_BITS + 1;
  localparam int POS_W     = ADDR_BITS + FRAC_BITS + 3;
  localparam int V_W       = POS_W + 1;
  localparam int DSH_W     = SPAN_W + ADDR_BITS + 1;
  localparam int MOD_STEPS = ADDR_BITS + 2;
  localparam int CNT_W     = $clog2(MOD_STEPS);
  localparam int DEPTH     = 1 << ADDR_BITS;
  localparam int PROD_W    = FRAC_BITS + SAMPLE_BITS + 2;

  localparam logic signed [V_W-1:0] PMAX = V_W'((64'sd1 <<< (POS_W - 1)) - 64'sd1);
  localparam logic signed [V_W-1:0] PMIN = -PMAX - V_W'(1);

  back_state_t state_r, state_nxt;

  logic signed [POS_W-1:0]       pos_r, pos_nxt;
  logic signed [SAMPLE_BITS-1:0] held_r, held_nxt;
  logic                          done_r, done_nxt;
  logic [POS_W-1:0]              mag_r, mag_nxt;
  logic [DSH_W-1:0]              dsh_r, dsh_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic                          neg_r, neg_nxt;
  logic [FRAC_BITS-1:0]          frac_r, frac_nxt;
  logic [ADDR_BITS-1:0]          i1_r, i1_nxt;
  logic signed [SAMPLE_BITS-1:0] s0_r, s0_nxt;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic                          out_finished_r, out_finished_nxt;

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] rd_data_r;
  logic [ADDR_BITS-1:0]          mem_addr;
  logic                          mem_we;

  logic                          out_free;
  logic                          out_load;

  logic signed [V_W-1:0]   span_v, span2_v, pos_v, step_v, off_v, v_sum, t_sum;
  logic [LEN_W-1:0]        len_m1;
  logic [POS_W-1:0]        end_pos_p;
  logic [POS_W-1:0]        span_p;
  logic signed [POS_W-1:0] tick_pos;
  logic                    tick_end;
  logic                    tick_slow;
  logic signed [POS_W-1:0] add_pos;
  logic [POS_W-1:0]        mag0;
  logic [DSH_W-1:0]        mag_ext;
  logic [POS_W-1:0]        t_fold;
  logic [ADDR_BITS-1:0]    off_idx;
  logic [FRAC_BITS-1:0]    off_frac;
  logic                    off_last;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [SAMPLE_BITS:0]   diff;
  logic signed [PROD_W-1:0]      fin_sum;

  assign span_v    = $signed({{(V_W-SPAN_W){1'b0}}, span});
  assign span2_v   = span_v + span_v;
  assign pos_v     = {pos_r[POS_W-1], pos_r};
  assign step_v    = {{(V_W-SPAN_W){q_step[SPAN_W-1]}}, q_step};
  assign off_v     = {{(V_W-SPAN_W){off_sat[SPAN_W-1]}}, off_sat};
  assign v_sum     = pos_v + step_v;
  assign len_m1    = len - LEN_W'(1);
  assign end_pos_p = {2'b00, len_m1, {FRAC_BITS{1'b0}}};
  assign span_p    = {2'b00, span};

  // tick: step then wrap or clamp
  always_comb begin
    tick_pos  = POS_W'(v_sum);
    tick_end  = 1'b0;
    tick_slow = 1'b0;
    if (looping) begin
      if (v_sum < 0) begin
        if (v_sum >= -span_v) begin
          tick_pos = POS_W'(v_sum + span_v);
        end else begin
          tick_slow = 1'b1;
        end
      end else if (v_sum >= span_v) begin
        if (v_sum < span2_v) begin
          tick_pos = POS_W'(v_sum - span_v);
        end else begin
          tick_slow = 1'b1;
        end
      end
    end else begin
      if (v_sum >= span_v) begin
        tick_pos = end_pos_p;
        tick_end = 1'b1;
      end else if (v_sum < 0) begin
        tick_pos = '0;
      end
    end
  end

  // add time saturates to the position range
  always_comb begin
    if (v_sum > PMAX) begin
      add_pos = POS_W'(PMAX);
    end else if (v_sum < PMIN) begin
      add_pos = POS_W'(PMIN);
    end else begin
      add_pos = POS_W'(v_sum);
    end
  end

  assign mag0    = (v_sum < 0) ? POS_W'(-v_sum) : POS_W'(v_sum);
  assign mag_ext = {{(DSH_W-POS_W){1'b0}}, mag_r};

  // read point with phase offset
  always_comb begin
    t_sum  = pos_v + off_v;
    t_fold = POS_W'(t_sum);
    if (looping) begin
      if (t_sum < 0) begin
        t_fold = POS_W'(t_sum + span_v);
      end else if (t_sum >= span_v) begin
        t_fold = POS_W'(t_sum - span_v);
      end
    end else begin
      if (t_sum >= span_v) begin
        t_fold = end_pos_p;
      end else if (t_sum < 0) begin
        t_fold = '0;
      end
    end
  end

  assign off_idx  = t_fold[FRAC_BITS +: ADDR_BITS];
  assign off_frac = t_fold[FRAC_BITS-1:0];
  assign off_last = ((LEN_W'(off_idx) + LEN_W'(1)) == len);

  assign frac_s  = $signed({1'b0, frac_r});
  assign diff    = {rd_data_r[SAMPLE_BITS-1], rd_data_r} - {s0_r[SAMPLE_BITS-1], s0_r};
  assign fin_sum = {{(PROD_W-SAMPLE_BITS){s0_r[SAMPLE_BITS-1]}}, s0_r} + (prod_r >>> FRAC_BITS);

  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EXEC: begin
        if (q_valid && (q_action == ACT_TICK)) begin
          state_nxt = tick_slow ? ST_MOD : ST_OFF;
        end
      end
      ST_MOD: begin
        if (cnt_r == '0) begin
          state_nxt = ST_MODFIX;
        end
      end
      ST_MODFIX: state_nxt = ST_OFF;
      ST_OFF:    state_nxt = ST_RD1;
      ST_RD1:    state_nxt = ST_MUL;
      ST_MUL:    state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_EXEC;
        end
      end
      default:   state_nxt = ST_EXEC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    mem_addr = '0;
    out_load = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        mem_addr = q_addr;
        if (q_valid) begin
          if (q_action == ACT_TICK) begin
            q_pop = 1'b1;
          end else if (out_free) begin
            q_pop    = 1'b1;
            out_load = 1'b1;
            mem_we   = (q_action == ACT_WRITE);
          end
        end
      end
      ST_OFF:  mem_addr = off_idx;
      ST_RD1:  mem_addr = i1_r;
      ST_FIN:  out_load = out_free;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    pos_nxt  = pos_r;
    held_nxt = held_r;
    done_nxt = done_r;
    mag_nxt  = mag_r;
    dsh_nxt  = dsh_r;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    frac_nxt = frac_r;
    i1_nxt   = i1_r;
    s0_nxt   = s0_r;
    prod_nxt = prod_r;
    unique case (state_r)
      ST_EXEC: begin
        if (q_pop) begin
          unique case (q_action)
            ACT_TICK: begin
              pos_nxt = tick_pos;
              if (tick_end) begin
                done_nxt = 1'b1;
              end
              mag_nxt = mag0;
              dsh_nxt = {span, {(ADDR_BITS+1){1'b0}}};
              cnt_nxt = CNT_W'(MOD_STEPS - 1);
              neg_nxt = (v_sum < 0);
            end
            ACT_RESET: begin
              pos_nxt  = '0;
              held_nxt = '0;
              done_nxt = 1'b0;
            end
            ACT_ADD:   pos_nxt = add_pos;
            ACT_WRITE: ;
          endcase
        end
      end
      ST_MOD: begin
        if (mag_ext >= dsh_r) begin
          mag_nxt = mag_r - dsh_r[POS_W-1:0];
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_MODFIX: begin
        if (neg_r && (mag_r != '0)) begin
          pos_nxt = span_p - mag_r;
        end else begin
          pos_nxt = mag_r;
        end
      end
      ST_OFF: begin
        frac_nxt = off_frac;
        if (off_last) begin
          i1_nxt = looping ? '0 : off_idx;
        end else begin
          i1_nxt = off_idx + ADDR_BITS'(1);
        end
      end
      ST_RD1: s0_nxt = rd_data_r;
      ST_MUL: prod_nxt = frac_s * diff;
      ST_FIN: begin
        if (out_load) begin
          held_nxt = fin_sum[SAMPLE_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt    = out_valid_r && out_stall;
    out_sample_nxt   = out_sample_r;
    out_finished_nxt = out_finished_r;
    if (out_load) begin
      out_valid_nxt    = 1'b1;
      out_sample_nxt   = held_nxt;
      out_finished_nxt = done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXEC;
      pos_r       <= '0;
      held_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      held_r      <= held_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r          <= mag_nxt;
    dsh_r          <= dsh_nxt;
    cnt_r          <= cnt_nxt;
    neg_r          <= neg_nxt;
    frac_r         <= frac_nxt;
    i1_r           <= i1_nxt;
    s0_r           <= s0_nxt;
    prod_r         <= prod_nxt;
    out_sample_r   <= out_sample_nxt;
    out_finished_r <= out_finished_nxt;
  end

  // sample table, single port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= q_value;
    end
    rd_data_r <= mem[mem_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_finished   = out_finished_r;

endmodule

// ===== rtl/wavetable_interp_player.sv =====
// ----------------------------------------------------------------------------
// wavetable_interp_player: wavetable oscillator with linear interpolation
// Plays a stored sample table through a two-entry item queue and a
// single-port table sequencer.
// ----------------------------------------------------------------------------
// Every accepted item returns one result: the held output sample and the
// finished flag. Items enter a two-entry queue, so input transfers continue
// while a result waits on the output register. Write, reset and add-time
// items load the output register from the execute state. A tick runs
// through position update, read-point calculation with the first table
// read, the second read through the single table port, the multiply, and
// the final add into the output register. In looping mode a tick whose
// stepped position lies more than one table span outside the table first
// runs a shift-subtract remainder. Table entries hold nothing defined
// until written.
// ----------------------------------------------------------------------------
module wavetable_interp_player #(
  parameter int ADDR_BITS   = wip_pkg::DEF_ADDR_BITS,
  parameter int FRAC_BITS   = wip_pkg::DEF_FRAC_BITS,
  parameter int SAMPLE_BITS = wip_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wip_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wip_pkg::REG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_action,
  input  logic [ADDR_BITS-1:0]              in_sample_index,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample_value,
  input  logic signed [wip_pkg::REG_W-1:0]  in_time_step,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample_out,
  output logic                              out_finished
);
  import wip_pkg::*;

  localparam int LEN_W  = ADDR_BITS + 1;
  localparam int SPAN_W = ADDR_BITS + FRAC_BITS + 1;

  logic                          q_full;
  logic                          q_push;
  action_t                       push_action;
  logic [ADDR_BITS-1:0]          push_addr;
  logic signed [SAMPLE_BITS-1:0] push_value;
  logic signed [SPAN_W-1:0]      push_step;
  logic                          q_valid;
  logic                          q_pop;
  action_t                       head_action;
  logic [ADDR_BITS-1:0]          head_addr;
  logic signed [SAMPLE_BITS-1:0] head_value;
  logic signed [SPAN_W-1:0]      head_step;
  logic [LEN_W-1:0]              len;
  logic [SPAN_W-1:0]             span;
  logic signed [SPAN_W-1:0]      off_sat;
  logic                          looping;

  wip_front #(
    .ADDR_BITS   (ADDR_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_sample_index (in_sample_index),
    .in_sample_value (in_sample_value),
    .in_time_step    (in_time_step),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_action        (push_action),
    .q_addr          (push_addr),
    .q_value         (push_value),
    .q_step          (push_step),
    .len             (len),
    .span            (span),
    .off_sat         (off_sat),
    .looping         (looping)
  );

  wip_queue #(
    .ADDR_BITS   (ADDR_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_action (push_action),
    .push_addr   (push_addr),
    .push_value  (push_value),
    .push_step   (push_step),
    .full        (q_full),
    .pop         (q_pop),
    .valid       (q_valid),
    .head_action (head_action),
    .head_addr   (head_addr),
    .head_value  (head_value),
    .head_step   (head_step)
  );

  wip_back #(
    .ADDR_BITS   (ADDR_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_action       (head_action),
    .q_addr         (head_addr),
    .q_value        (head_value),
    .q_step         (head_step),
    .len            (len),
    .span           (span),
    .off_sat        (off_sat),
    .looping        (looping),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_finished   (out_finished)
  );

endmodule
